>>> src/dmf_pkg.sv
// ----------------------------------------------------------------------------
// Mixed cell stream deframer package
// Shared types, codes and the node count table.
// ----------------------------------------------------------------------------
package dmf_pkg;

  localparam int unsigned IndexBits = 32;
  localparam logic [31:0] IndexMask = (IndexBits >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << IndexBits) - 64'd1);

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhCount   = 2'd1;
  localparam logic [1:0] PhNodes   = 2'd2;
  localparam logic [1:0] PhDiscard = 2'd3;

  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrUnknown   = 2'd1,
    ErrPolyCount = 2'd2,
    ErrTruncated = 2'd3
  } err_e;

  localparam logic [5:0]  CodePolyline = 6'd2;
  localparam logic [31:0] PolyCount    = 32'd2;

  typedef struct packed {
    logic [31:0] node_index;
    logic [5:0]  cell_type;
    logic [4:0]  node_slot;
    logic        cell_done;
    logic        block_start;
    err_e        error_code;
    logic        stream_end;
  } res_t;

  // has_res low: stream end with no result, only clears the type history
  typedef struct packed {
    logic        has_res;
    logic        first;
    logic [31:0] node_index;
    logic [5:0]  cell_type;
    logic [4:0]  node_slot;
    logic        cell_done;
    err_e        error_code;
    logic        stream_end;
  } rec_t;

  function automatic logic [4:0] node_count(logic [5:0] code);
    logic [4:0] n;
    unique case (code)
      6'h01:   n = 5'd1;
      6'h02:   n = 5'd2;
      6'h04:   n = 5'd3;
      6'h05:   n = 5'd4;
      6'h06:   n = 5'd4;
      6'h07:   n = 5'd5;
      6'h08:   n = 5'd6;
      6'h09:   n = 5'd8;
      6'h22:   n = 5'd3;
      6'h23:   n = 5'd9;
      6'h24:   n = 5'd6;
      6'h25:   n = 5'd8;
      6'h26:   n = 5'd10;
      6'h27:   n = 5'd13;
      6'h28:   n = 5'd15;
      6'h29:   n = 5'd18;
      6'h30:   n = 5'd20;
      6'h31:   n = 5'd24;
      6'h32:   n = 5'd27;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

>>> src/mixed_cell_stream_deframer.sv
// ----------------------------------------------------------------------------
// Mixed cell stream deframer
// Splits a flat connectivity word stream into per-node results.
// ----------------------------------------------------------------------------
// Path: each word's record is registered in the record queue, then its result
// in the result queue once that queue has room; the result queue drives the outputs.
// Throughput: one word per cycle; the front end and back end each take one
// record per cycle, and full rises only when the two-entry record queue fills.
// Reset: asynchronous, active low; clears framing, type history and queues.
module mixed_cell_stream_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] word_i,
  input  logic        last_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] node_index_o,
  output logic [5:0]  cell_type_o,
  output logic [4:0]  node_slot_o,
  output logic        cell_done_o,
  output logic        block_start_o,
  output logic [1:0]  error_code_o,
  output logic        stream_end_o
);
  import dmf_pkg::*;

  rec_t rec_f, rec_b;
  res_t res;
  logic rec_f_valid, rec_pop, rec_empty, take;

  assign take = push && !full;

  dmf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .word_i      (word_i),
    .last_word_i (last_word_i),
    .rec_valid_o (rec_f_valid),
    .rec_o       (rec_f)
  );

  dmf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_f_valid),
    .rec_i   (rec_f),
    .full_o  (full),
    .pop_i   (rec_pop),
    .rec_o   (rec_b),
    .empty_o (rec_empty)
  );

  dmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_empty_i (rec_empty),
    .rec_i       (rec_b),
    .rec_pop_o   (rec_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign node_index_o  = res.node_index;
  assign cell_type_o   = res.cell_type;
  assign node_slot_o   = res.node_slot;
  assign cell_done_o   = res.cell_done;
  assign block_start_o = res.block_start;
  assign error_code_o  = res.error_code;
  assign stream_end_o  = res.stream_end;

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_code_o != ErrNone) |->
      (node_index_o == '0 && !cell_done_o && !block_start_o))
    else $error("error result carries node data");

  a_bstart_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && block_start_o) |-> (node_slot_o == '0))
    else $error("block start off the first slot");

  a_unknown_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_code_o == ErrUnknown) |-> (cell_type_o == '0))
    else $error("unknown type error with nonzero type");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !rec_pop) |=> empty)
    else $error("result appeared without a record");

endmodule

>>> src/dmf_front.sv
// ----------------------------------------------------------------------------
// Deframer front end
// Tracks the cell framing, classifies each word and builds transfer records.
// ----------------------------------------------------------------------------
module dmf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [31:0]       word_i,
  input  logic              last_word_i,
  output logic              rec_valid_o,
  output dmf_pkg::rec_t     rec_o
);
  import dmf_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [5:0] type_q, type_d;
  logic [4:0] left_q, left_d;
  logic [4:0] slot_q, slot_d;
  logic [4:0] n_hdr;
  logic [4:0] left_dec;
  logic       done;
  logic       fail;

  assign n_hdr    = (word_i[31:6] == '0) ? node_count(word_i[5:0]) : 5'd0;
  assign left_dec = left_q - 5'd1;
  assign done     = (left_dec == 5'd0);

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    left_d      = left_q;
    slot_d      = slot_q;
    rec_valid_o = 1'b0;
    fail        = 1'b0;
    rec_o       = '0;
    rec_o.stream_end = last_word_i;
    if (take_i) begin
      if (phase_q == PhDiscard) begin
        rec_valid_o = last_word_i;
      end else if (phase_q == PhCount) begin
        rec_valid_o   = 1'b1;
        rec_o.has_res = 1'b1;
        rec_o.cell_type = CodePolyline;
        if (word_i != PolyCount) begin
          fail             = 1'b1;
          rec_o.error_code = ErrPolyCount;
        end else begin
          left_d  = node_count(CodePolyline);
          slot_d  = '0;
          phase_d = PhNodes;
          rec_valid_o = last_word_i;
          if (last_word_i) begin
            fail             = 1'b1;
            rec_o.cell_type  = type_q;
            rec_o.error_code = ErrTruncated;
          end
        end
      end else if (phase_q == PhNodes && left_q != '0) begin
        rec_valid_o     = 1'b1;
        rec_o.has_res   = 1'b1;
        rec_o.cell_type = type_q;
        rec_o.node_slot = slot_q;
        left_d          = left_dec;
        if (last_word_i && !done) begin
          fail             = 1'b1;
          rec_o.error_code = ErrTruncated;
        end else begin
          rec_o.first      = (slot_q == '0);
          rec_o.node_index = word_i & IndexMask;
          rec_o.cell_done  = done;
          if (done) begin
            phase_d = PhHeader;
            slot_d  = '0;
          end else begin
            slot_d = slot_q + 5'd1;
          end
        end
      end else begin
        rec_o.has_res = 1'b1;
        if (n_hdr == '0) begin
          rec_valid_o      = 1'b1;
          fail             = 1'b1;
          rec_o.error_code = ErrUnknown;
        end else begin
          type_d = word_i[5:0];
          slot_d = '0;
          if (word_i[5:0] == CodePolyline) begin
            phase_d = PhCount;
            left_d  = '0;
          end else begin
            phase_d = PhNodes;
            left_d  = n_hdr;
          end
          rec_valid_o = last_word_i;
          if (last_word_i) begin
            fail             = 1'b1;
            rec_o.cell_type  = word_i[5:0];
            rec_o.error_code = ErrTruncated;
          end
        end
      end
      if (fail && !last_word_i) begin
        phase_d = PhDiscard;
      end
      if (last_word_i) begin
        phase_d = PhHeader;
        type_d  = '0;
        left_d  = '0;
        slot_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      type_q  <= '0;
      left_q  <= '0;
      slot_q  <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      left_q  <= left_d;
      slot_q  <= slot_d;
    end
  end

endmodule

>>> src/dmf_queue.sv
// ----------------------------------------------------------------------------
// Deframer record queue
// Two-entry queue of records between the front and back ends.
// ----------------------------------------------------------------------------
module dmf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dmf_pkg::rec_t rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output dmf_pkg::rec_t rec_o,
  output logic          empty_o
);
  import dmf_pkg::*;

  rec_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> src/dmf_back.sv
// ----------------------------------------------------------------------------
// Deframer back end
// Tracks the type run for block starts and holds results for the reader.
// ----------------------------------------------------------------------------
module dmf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rec_empty_i,
  input  dmf_pkg::rec_t rec_i,
  output logic          rec_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output dmf_pkg::res_t res_o
);
  import dmf_pkg::*;

  res_t       mem_q [2];
  res_t       res_new;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic [5:0] prev_q, prev_d;
  logic       out_pop, out_push;

  assign empty_o  = (cnt_q == 2'd0);
  assign out_pop  = pop_i && !empty_o;
  assign res_o    = mem_q[rd_q];
  assign rec_pop_o = !rec_empty_i && (!rec_i.has_res || cnt_q != 2'd2 || out_pop);
  assign out_push = rec_pop_o && rec_i.has_res;

  always_comb begin
    res_new.node_index  = rec_i.node_index;
    res_new.cell_type   = rec_i.cell_type;
    res_new.node_slot   = rec_i.node_slot;
    res_new.cell_done   = rec_i.cell_done;
    res_new.block_start = rec_i.first && (rec_i.cell_type != prev_q);
    res_new.error_code  = rec_i.error_code;
    res_new.stream_end  = rec_i.stream_end;
    prev_d = prev_q;
    if (rec_pop_o) begin
      if (rec_i.first) prev_d = rec_i.cell_type;
      if (rec_i.stream_end) prev_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      mem_q[wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= '0;
      prev_q <= '0;
    end else begin
      if (out_push) wr_q <= ~wr_q;
      if (out_pop)  rd_q <= ~rd_q;
      cnt_q  <= cnt_q + 2'(out_push) - 2'(out_pop);
      prev_q <= prev_d;
    end
  end

endmodule
